### design/vfd_pkg.sv
// Shared types, codes and helper functions for the variable-length float stream decoder.
// Used by vfd_front, vfd_queue, vfd_back and var_float_stream_decoder; no dependencies.
`default_nettype none

package vfd_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] LEAD_NEGATIVE = 8'hFF;
   localparam logic [7:0] LEAD_FLAG     = 8'h80;
   localparam logic [7:0] SMALL_MASK    = 8'h7F;

   localparam logic [2:0] NEG_PAYLOAD_BYTES = 3'd4;
   localparam logic [2:0] POS_PAYLOAD_BYTES = 3'd3;

   typedef enum logic [1:0] {
      FORM_SMALL = 2'd0,
      FORM_NEG   = 2'd1,
      FORM_POS   = 2'd2
   } form_type;

   typedef struct packed {
      form_type    form;
      logic [31:0] payload;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Exact single-precision bits for the small integer coded as (code - 1).
   function automatic logic [31:0] small_int_bits(input logic [6:0] code);
      logic [6:0]  mag;
      logic [2:0]  msb;
      logic [7:0]  expo;
      logic [29:0] shifted;
      begin
         mag = code - 7'd1;
         msb = 3'd0;
         expo = 8'd0;
         shifted = 30'd0;
         if (code == 7'd1) begin
            small_int_bits = 32'h0000_0000;
         end else if (code == 7'd0) begin
            small_int_bits = 32'hBF80_0000;
         end else begin
            for (int i = 0; i < 7; i++) begin
               if (mag[i]) begin
                  msb = 3'(i);
               end
            end
            expo = 8'd127 + {5'd0, msb};
            shifted = {23'd0, mag} << (5'd23 - {2'd0, msb});
            small_int_bits = {1'b0, expo, shifted[22:0]};
         end
      end
   endfunction

endpackage

`default_nettype wire

### design/var_float_stream_decoder.sv
// Top level of the variable-length float stream decoder: front end, entry queue, back end.
// Depends on vfd_pkg, vfd_front, vfd_queue and vfd_back.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/req_stall | req_in_byte[7:0]
//   rsp     | out       | rsp_valid/rsp_stall | rsp_value_bits[31:0], rsp_form[1:0]
//
// One byte is accepted per cycle while the queue has room; a decoded entry is written
// into the queue and then leaves through a registered output stage.
// The queue of QUEUE_DEPTH entries decouples byte intake from response stalls.
// Synchronous reset clears the decode state, the queue and the response valid.
// When the output is stalled the queue fills, then req_stall rises.
`default_nettype none

module var_float_stream_decoder #(
   parameter int QUEUE_DEPTH = vfd_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_value_bits,
   output logic [1:0]  rsp_form
);

   vfd_pkg::queue_status_type status;
   vfd_pkg::entry_type        push_entry;
   vfd_pkg::entry_type        head;
   logic                      push;
   logic                      pop;

   vfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .status      (status),
      .push        (push),
      .push_entry  (push_entry)
   );

   vfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   vfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .status         (status),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value_bits (rsp_value_bits),
      .rsp_form       (rsp_form)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("entry pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("entry popped from an empty queue");

   a_status_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(status.empty && status.full))
      else $error("queue reports empty and full together");

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped entry did not reach the response register");

endmodule

`default_nettype wire

### design/vfd_front.sv
// Front end: accepts coded bytes, tracks the lead byte and gathers multi-byte words.
// Pushes one completed entry per finished value into the queue; depends on vfd_pkg.
`default_nettype none

module vfd_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire  [7:0]                req_in_byte,
   output logic                      req_stall,
   input  vfd_pkg::queue_status_type status,
   output logic                      push,
   output vfd_pkg::entry_type        push_entry
);

   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [23:0] word_ff, word_in;
   logic        negative_ff, negative_in;
   logic        accept;

   assign req_stall = status.full;
   assign accept    = req_valid && !status.full;

   always_comb begin
      bytes_left_in      = bytes_left_ff;
      word_in            = word_ff;
      negative_in        = negative_ff;
      push               = 1'b0;
      push_entry.form    = vfd_pkg::FORM_SMALL;
      push_entry.payload = {word_ff, req_in_byte};
      if (accept) begin
         if (bytes_left_ff != 3'd0) begin
            if (bytes_left_ff > 3'd1) begin
               word_in       = {word_ff[15:0], req_in_byte};
               bytes_left_in = bytes_left_ff - 3'd1;
            end else begin
               push            = 1'b1;
               push_entry.form = negative_ff ? vfd_pkg::FORM_NEG : vfd_pkg::FORM_POS;
               bytes_left_in   = 3'd0;
               word_in         = 24'd0;
               negative_in     = 1'b0;
            end
         end else if (req_in_byte == vfd_pkg::LEAD_NEGATIVE) begin
            negative_in   = 1'b1;
            word_in       = 24'd0;
            bytes_left_in = vfd_pkg::NEG_PAYLOAD_BYTES;
         end else if ((req_in_byte & vfd_pkg::LEAD_FLAG) != 8'd0) begin
            push               = 1'b1;
            push_entry.form    = vfd_pkg::FORM_SMALL;
            push_entry.payload = {24'd0, req_in_byte & vfd_pkg::SMALL_MASK};
         end else begin
            negative_in   = 1'b0;
            word_in       = {16'd0, req_in_byte};
            bytes_left_in = vfd_pkg::POS_PAYLOAD_BYTES;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 3'd0;
         word_ff       <= 24'd0;
         negative_ff   <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         word_ff       <= word_in;
         negative_ff   <= negative_in;
      end
   end

endmodule

`default_nettype wire

### design/vfd_queue.sv
// Short FIFO of decoded entries between the front end and the back end.
// Circular buffer with read and write pointers and an occupancy count; depends on vfd_pkg.
`default_nettype none

module vfd_queue #(
   parameter int DEPTH = vfd_pkg::QUEUE_DEPTH
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  vfd_pkg::entry_type        push_entry,
   input  wire                       pop,
   output vfd_pkg::entry_type        head,
   output vfd_pkg::queue_status_type status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   vfd_pkg::entry_type slots_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### design/vfd_back.sv
// Back end: takes queued entries, converts small integers to float bits and holds the response.
// Owns the response output register; depends on vfd_pkg.
`default_nettype none

module vfd_back (
   input  wire                       clock,
   input  wire                       reset,
   input  vfd_pkg::queue_status_type status,
   input  vfd_pkg::entry_type        head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic [31:0]               rsp_value_bits,
   output logic [1:0]                rsp_form
);

   logic        valid_ff, valid_in;
   logic [31:0] bits_ff, bits_in;
   logic [1:0]  form_ff, form_in;

   assign pop = !status.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      bits_in  = bits_ff;
      form_in  = form_ff;
      if (pop) begin
         valid_in = 1'b1;
         form_in  = head.form;
         case (head.form)
            vfd_pkg::FORM_SMALL: bits_in = vfd_pkg::small_int_bits(head.payload[6:0]);
            vfd_pkg::FORM_NEG,
            vfd_pkg::FORM_POS:   bits_in = head.payload;
            default:             bits_in = head.payload;
         endcase
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      form_ff <= form_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_value_bits = bits_ff;
   assign rsp_form       = form_ff;

endmodule

`default_nettype wire

### bench/var_float_stream_decoder_tb.sv
// Self-checking testbench for var_float_stream_decoder: drives coded byte streams with random
// idle gaps and output stalls, and checks each decoded float against a built-in predictor.
// Depends on vfd_pkg and the var_float_stream_decoder RTL.

module var_float_stream_decoder_tb;

   localparam int REQUEST_COUNT = 2000;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      logic [31:0]       value_bits;
      vfd_pkg::form_type form;
   } decoded_value_type;

   class zfloat_tracker_type;
      decoded_value_type expected_values[$];
      logic [2:0]        payload_left;
      logic [23:0]       gathered;
      logic              negative_pending;
      int                errors;

      function new();
         payload_left = 3'd0;
         gathered = 24'd0;
         negative_pending = 1'b0;
         errors = 0;
      endfunction

      function logic [31:0] small_float(input logic [6:0] code);
         int          number;
         int          magnitude;
         int          msb;
         logic [31:0] mantissa;
         number = int'(code) - 1;
         magnitude = (number < 0) ? -number : number;
         if (magnitude == 0) return 32'd0;
         msb = 0;
         while ((magnitude >> (msb + 1)) != 0) msb++;
         mantissa = 32'(magnitude) << (23 - msb);
         return {(number < 0), 8'(127 + msb), mantissa[22:0]};
      endfunction

      function void push_value(input logic [31:0] bits, input vfd_pkg::form_type form);
         decoded_value_type entry;
         entry.value_bits = bits;
         entry.form = form;
         expected_values.push_back(entry);
      endfunction

      function void note_request(input logic [7:0] in_byte);
         if (payload_left != 3'd0) begin
            if (payload_left > 3'd1) begin
               gathered = {gathered[15:0], in_byte};
               payload_left = payload_left - 3'd1;
            end else begin
               push_value({gathered, in_byte},
                          negative_pending ? vfd_pkg::FORM_NEG : vfd_pkg::FORM_POS);
               payload_left = 3'd0;
               gathered = 24'd0;
               negative_pending = 1'b0;
            end
         end else if (in_byte == vfd_pkg::LEAD_NEGATIVE) begin
            negative_pending = 1'b1;
            gathered = 24'd0;
            payload_left = vfd_pkg::NEG_PAYLOAD_BYTES;
         end else if ((in_byte & vfd_pkg::LEAD_FLAG) != 8'd0) begin
            push_value(small_float(in_byte[6:0]), vfd_pkg::FORM_SMALL);
         end else begin
            negative_pending = 1'b0;
            gathered = {16'd0, in_byte};
            payload_left = vfd_pkg::POS_PAYLOAD_BYTES;
         end
      endfunction

      task report(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(input logic [31:0] value_bits, input logic [1:0] form);
         decoded_value_type entry;
         if (expected_values.size() == 0) begin
            report($sformatf("unexpected response value %h form %0d", value_bits, form));
         end else begin
            entry = expected_values.pop_front();
            if (value_bits !== entry.value_bits)
               report($sformatf("value %h, expected %h", value_bits, entry.value_bits));
            if (form !== entry.form)
               report($sformatf("form %0d, expected %0d", form, entry.form));
         end
      endtask

      function int pending();
         return expected_values.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_value_bits;
   logic [1:0]  rsp_form;

   zfloat_tracker_type tracker = new();
   bit                 long_hold = 1'b0;
   int                 requests_sent = 0;
   int                 sender_burst = 0;
   int                 cycle_count = 0;

   var_float_stream_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value_bits (rsp_value_bits),
      .rsp_form       (rsp_form)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Mostly random waits, with occasional runs of back-to-back requests.
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   task send_request(input logic [7:0] in_byte);
      int gap;
      gap = draw_wait(sender_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= in_byte;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(in_byte);
      requests_sent++;
      if (requests_sent == REQUEST_COUNT / 2) long_hold = 1'b1;
   endtask

   task send_word(input logic [7:0] lead, input logic [31:0] payload, input int length);
      send_request(lead);
      for (int i = length - 1; i >= 0; i--) send_request(payload[8 * i +: 8]);
   endtask

   initial begin : response_side
      int wait_cycles;
      int burst;
      burst = 0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         wait_cycles = draw_wait(burst);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         tracker.check_response(rsp_value_bits, rsp_form);
      end
   end

   initial begin : request_side
      int kind;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Small integers at both ends, including minus one and zero.
      send_request(8'h80);
      send_request(8'h81);
      send_request(8'h82);
      send_request(8'hFE);
      // Negative form with an all-ones payload, then one whose sign bit is clear.
      send_word(8'hFF, 32'hFFFF_FFFF, 4);
      send_word(8'hFF, 32'h3F80_0000, 4);
      // Positive forms at the largest and smallest lead bytes.
      send_word(8'h7F, 32'h00FF_FFFF, 3);
      send_word(8'h00, 32'h0000_0000, 3);

      while (requests_sent < REQUEST_COUNT) begin
         kind = $urandom_range(0, 9);
         if (kind < 4)
            send_request(8'($urandom_range(8'h80, 8'hFE)));
         else if (kind < 7)
            send_word(8'($urandom_range(0, 8'h7F)), $urandom, 3);
         else if (kind < 9)
            send_word(vfd_pkg::LEAD_NEGATIVE, $urandom, 4);
         else
            send_request(8'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d responses never arrived", tracker.pending()));
      if (tracker.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
